[design/lcdw_pkg.sv]
package lcdw_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic       MODE_CHAR = 1'b0;
  localparam logic       MODE_POS  = 1'b1;

  localparam logic       RS_CMD  = 1'b0;
  localparam logic       RS_DATA = 1'b1;

  localparam logic [7:0] TAB_STEP    = 8'd3;
  localparam logic [7:0] TAB_LIMIT   = 8'd15;
  localparam logic [7:0] CMD_SET_ADR = 8'h80;

  // One queued job: an optional data byte followed by an optional address command.
  typedef struct packed {
    logic       data_en;
    logic [7:0] data_byte;
    logic       addr_en;
    logic [7:0] addr_byte;
  } job_t;

  function automatic logic [7:0] make_addr(input logic [7:0] col, input logic row);
    make_addr = CMD_SET_ADR | {4'h0, col[3:0]} | {1'b0, row, 6'b0};
  endfunction

endpackage

[design/lcdw_front.sv]
module lcdw_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          mode,
  input  logic [7:0]    char_code,
  input  logic [3:0]    start_column,
  input  logic          start_row,
  input  logic          queue_full,
  output logic          push,
  output lcdw_pkg::job_t push_job
);
  import lcdw_pkg::*;

  logic [7:0] cursor_column, cursor_column_next;
  logic       cursor_row, cursor_row_next;
  logic [7:0] tab_sum;
  logic [7:0] col_inc;
  logic       accept;
  job_t       job;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign tab_sum  = cursor_column + TAB_STEP;
  assign col_inc  = cursor_column + 8'd1;

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    job                = '0;
    if (mode == MODE_POS) begin
      cursor_column_next = {4'h0, start_column};
      cursor_row_next    = start_row;
      job.addr_en        = 1'b1;
    end else begin
      unique case (char_code) inside
        CH_NUL, CH_BSLASH: begin
        end
        CH_CR: begin
          cursor_column_next = 8'd0;
          job.addr_en        = 1'b1;
        end
        CH_TAB: begin
          cursor_column_next = (tab_sum > TAB_LIMIT) ? TAB_LIMIT : tab_sum;
          job.addr_en        = 1'b1;
        end
        CH_BS: begin
          if (cursor_column[3:0] != 4'h0) begin
            cursor_column_next = cursor_column - 8'd1;
          end
          job.addr_en = 1'b1;
        end
        CH_LF: begin
          if (cursor_column[3:0] != 4'h0) begin
            cursor_column_next = cursor_column - 8'd1;
            cursor_row_next    = ~cursor_row;
            job.addr_en        = 1'b1;
          end
        end
        default: begin
          job.data_en        = 1'b1;
          job.data_byte      = char_code;
          cursor_column_next = col_inc;
          // Crossing a 16-column boundary moves to the other line.
          if (col_inc[3:0] == 4'h0) begin
            cursor_row_next = ~cursor_row;
            job.addr_en     = 1'b1;
          end
        end
      endcase
    end
    job.addr_byte = make_addr(cursor_column_next, cursor_row_next);
  end

  assign push     = accept && (job.data_en || job.addr_en);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= 8'd0;
      cursor_row    <= 1'b0;
    end else if (accept) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule

[design/lcdw_queue.sv]
module lcdw_queue #(
  parameter int QueueDepth = lcdw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcdw_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lcdw_pkg::job_t head
);
  import lcdw_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full    = (count == CntW'(QueueDepth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/lcdw_back.sv]
module lcdw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           queue_empty,
  input  lcdw_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           reg_select,
  output logic [3:0]     nibble,
  output logic           last
);
  import lcdw_pkg::*;

  // pos[1] selects the second byte of a two-byte job, pos[0] the low nibble.
  logic [1:0] pos;
  logic       load;
  logic       sel_data;
  logic [7:0] cur_byte;
  logic       cur_last;

  assign load     = (!out_valid || !out_stall) && !queue_empty;
  assign sel_data = head.data_en && !pos[1];
  assign cur_byte = sel_data ? head.data_byte : head.addr_byte;
  assign cur_last = pos[0] && (pos[1] || !(head.data_en && head.addr_en));
  assign pop      = load && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= cur_last ? 2'd0 : pos + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      reg_select <= sel_data ? RS_DATA : RS_CMD;
      nibble     <= pos[0] ? cur_byte[3:0] : cur_byte[7:4];
      last       <= cur_last;
    end
  end

endmodule

[design/char_lcd_text_cursor_writer.sv]
// Each item's first nibble beat passes through the job queue and then the output register.
// Throughput: one nibble beat per cycle from the output register while out_stall is low
// and jobs are queued; an item causes two beats per byte, two or four in all, or none.
// A four-entry job queue lets the input side run ahead of the nibble sequencer.
// Synchronous reset clears the cursor to column 0, row 0 and empties the queue.
module char_lcd_text_cursor_writer #(
  parameter int QueueDepth = lcdw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] char_code,
  input  logic [3:0] start_column,
  input  logic       start_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       reg_select,
  output logic [3:0] nibble,
  output logic       last
);
  import lcdw_pkg::*;

  logic queue_full, queue_empty, push, pop;
  job_t push_job, head;

  lcdw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .char_code    (char_code),
    .start_column (start_column),
    .start_row    (start_row),
    .queue_full   (queue_full),
    .push         (push),
    .push_job     (push_job)
  );

  lcdw_queue #(.QueueDepth(QueueDepth)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  lcdw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reg_select  (reg_select),
    .nibble      (nibble),
    .last        (last)
  );

endmodule
